// ===== rtl/dmrc_pkg.sv =====
// Shared types and constants for the direct-mapped read cache.
package dmrc_pkg;

	localparam int ADDR_W   = 24;
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ  = 2'd0,
		CMD_FILL  = 2'd1,
		CMD_INVAL = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT   = 3'd0,
		ST_MISS  = 3'd1,
		ST_TAKEN = 3'd2,
		ST_DONE  = 3'd3,
		ST_INVAL = 3'd4,
		ST_ERROR = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		RK_LOOKUP,
		RK_TAKEN,
		RK_DONE,
		RK_INVAL,
		RK_ERROR
	} kind_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_ISSUE,
		S_FILL_RD,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic  in_ready;
		logic  lookup_rd;
		logic  fill_wr;
		logic  fill_rd;
		logic  sweep_wr;
		logic  emit_load;
		kind_t kind;
	} ctl_cmd_t;

	typedef struct packed {
		logic             in_valid;
		logic [CMD_W-1:0] cmd;
		logic             fill_pending;
		logic             fill_last;
		logic             sweep_last;
		logic             out_free;
	} ctl_status_t;

endpackage

// ===== rtl/dmrc_req_if.sv =====
// Request channel of the cache: command, address and fill word.
interface dmrc_req_if;
	logic                     valid;
	logic                     ready;
	logic [dmrc_pkg::CMD_W-1:0]  cmd;
	logic [dmrc_pkg::ADDR_W-1:0] addr;
	logic [dmrc_pkg::DATA_W-1:0] fill_word;

	modport source (output valid, output cmd, output addr, output fill_word, input ready);
	modport sink (input valid, input cmd, input addr, input fill_word, output ready);
endinterface

// ===== rtl/dmrc_rsp_if.sv =====
// Result channel of the cache: status, data, fill address and counters.
interface dmrc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [dmrc_pkg::STATUS_W-1:0] status;
	logic [dmrc_pkg::DATA_W-1:0]   read_data;
	logic [dmrc_pkg::ADDR_W-1:0]   fill_base;
	logic [dmrc_pkg::DATA_W-1:0]   hits_seen;
	logic [dmrc_pkg::DATA_W-1:0]   misses_seen;

	modport source (output valid, output status, output read_data, output fill_base,
		output hits_seen, output misses_seen, input ready);
	modport sink (input valid, input status, input read_data, input fill_base,
		input hits_seen, input misses_seen, output ready);
endinterface

// ===== rtl/dmrc_ctrl.sv =====
// Controller state machine of the cache: sequences lookups, fills, results and clearing.
module dmrc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dmrc_pkg::ctl_status_t sts,
	output dmrc_pkg::ctl_cmd_t    ctl
);
	import dmrc_pkg::*;

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			kind_q  <= RK_ERROR;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		kind_d        = kind_q;
		ctl           = '0;
		ctl.kind      = kind_q;
		case (state_q)
			S_SWEEP: begin
				ctl.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				ctl.in_ready = 1'b1;
				if (sts.in_valid) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				state_d = S_EMIT;
				kind_d  = RK_ERROR;
				case (sts.cmd)
					CMD_READ: begin
						if (!sts.fill_pending) begin
							ctl.lookup_rd = 1'b1;
							kind_d        = RK_LOOKUP;
						end
					end
					CMD_FILL: begin
						if (sts.fill_pending) begin
							ctl.fill_wr = 1'b1;
							if (sts.fill_last) begin
								kind_d  = RK_DONE;
								state_d = S_FILL_RD;
							end else begin
								kind_d = RK_TAKEN;
							end
						end
					end
					CMD_INVAL: begin
						kind_d = RK_INVAL;
					end
					default: begin
						kind_d = RK_ERROR;
					end
				endcase
			end
			S_FILL_RD: begin
				ctl.fill_rd = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					ctl.emit_load = 1'b1;
					state_d       = (kind_q == RK_INVAL) ? S_SWEEP : S_IDLE;
				end
			end
			default: begin
				state_d = S_SWEEP;
			end
		endcase
	end

endmodule

// ===== rtl/dmrc_dp.sv =====
// Datapath of the cache: request and fill registers, tag and data memories, counters, result register.
module dmrc_dp #(
	parameter int LINE_BYTES = 256,
	parameter int NUM_LINES  = 256,
	parameter int ADDR_BITS  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dmrc_pkg::ctl_cmd_t    ctl,
	output dmrc_pkg::ctl_status_t sts,
	dmrc_req_if.sink              req,
	dmrc_rsp_if.source            rsp
);
	import dmrc_pkg::*;

	localparam int OFF_W  = $clog2(LINE_BYTES);
	localparam int IDX_W  = $clog2(NUM_LINES);
	localparam int WPL_W  = OFF_W - 2;
	localparam int SLOT_W = IDX_W + WPL_W;
	localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
	localparam int AW_EFF = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = ({ADDR_W{1'b1}} >> (ADDR_W - AW_EFF))
		& ~(ADDR_W'(3));

	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] fill_word_q;

	logic              pending_q;
	logic [ADDR_W-1:0] paddr_q;
	logic [WPL_W-1:0]  pos_q;
	logic [IDX_W-1:0]  sweep_q;
	logic [DATA_W-1:0] hits_q, misses_q;

	logic [TAG_W:0]    tag_mem [NUM_LINES];
	logic [DATA_W-1:0] data_mem [NUM_LINES << WPL_W];
	logic [TAG_W:0]    tag_rd_q;
	logic [DATA_W-1:0] data_rd_q;

	logic              out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [DATA_W-1:0] rdata_q;
	logic [ADDR_W-1:0] base_q;

	logic [ADDR_W-1:0] a_m, p_m;
	logic [IDX_W-1:0]  a_idx, p_idx;
	logic [TAG_W-1:0]  a_tag, p_tag;
	logic [SLOT_W-1:0] a_slot, p_slot, fill_slot, rd_slot;
	logic              accept, hit, out_free;
	logic              tag_we;
	logic [IDX_W-1:0]  tag_waddr;
	logic [TAG_W:0]    tag_wdata;
	logic [DATA_W-1:0] hits_d, misses_d;
	status_t           status_d;
	logic [DATA_W-1:0] rdata_d;
	logic [ADDR_W-1:0] base_d;

	assign accept    = req.valid && ctl.in_ready;
	assign req.ready = ctl.in_ready;

	assign a_m    = addr_q & ADDR_MASK;
	assign p_m    = paddr_q;
	assign a_idx  = a_m[OFF_W +: IDX_W];
	assign p_idx  = p_m[OFF_W +: IDX_W];
	assign a_tag  = a_m[ADDR_W-1 -: TAG_W];
	assign p_tag  = p_m[ADDR_W-1 -: TAG_W];
	assign a_slot = {a_idx, a_m[OFF_W-1:2]};
	assign p_slot = {p_idx, p_m[OFF_W-1:2]};
	assign fill_slot = {p_idx, pos_q};
	assign rd_slot   = ctl.lookup_rd ? a_slot : p_slot;

	assign hit      = tag_rd_q[TAG_W] && (tag_rd_q[TAG_W-1:0] == a_tag);
	assign out_free = !out_valid_q || rsp.ready;

	assign sts.in_valid     = req.valid;
	assign sts.cmd          = cmd_q;
	assign sts.fill_pending = pending_q;
	assign sts.fill_last    = (pos_q == {WPL_W{1'b1}});
	assign sts.sweep_last   = (sweep_q == {IDX_W{1'b1}});
	assign sts.out_free     = out_free;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= req.cmd;
			addr_q      <= req.addr;
			fill_word_q <= req.fill_word;
		end
	end

	assign tag_we    = ctl.sweep_wr || (ctl.fill_wr && sts.fill_last);
	assign tag_waddr = ctl.sweep_wr ? sweep_q : p_idx;
	assign tag_wdata = ctl.sweep_wr ? '0 : {1'b1, p_tag};

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_waddr] <= tag_wdata;
		end
		if (ctl.lookup_rd) begin
			tag_rd_q <= tag_mem[a_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fill_wr) begin
			data_mem[fill_slot] <= fill_word_q;
		end
		if (ctl.lookup_rd || ctl.fill_rd) begin
			data_rd_q <= data_mem[rd_slot];
		end
	end

	always_comb begin
		hits_d   = hits_q;
		misses_d = misses_q;
		status_d = ST_ERROR;
		rdata_d  = '0;
		base_d   = '0;
		case (ctl.kind)
			RK_LOOKUP: begin
				if (hit) begin
					status_d = ST_HIT;
					rdata_d  = data_rd_q;
					hits_d   = (hits_q == {DATA_W{1'b1}}) ? hits_q : hits_q + 1'b1;
				end else begin
					status_d = ST_MISS;
					base_d   = {a_m[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
					misses_d = (misses_q == {DATA_W{1'b1}}) ? misses_q : misses_q + 1'b1;
				end
			end
			RK_TAKEN: begin
				status_d = ST_TAKEN;
			end
			RK_DONE: begin
				status_d = ST_DONE;
				rdata_d  = data_rd_q;
			end
			RK_INVAL: begin
				status_d = ST_INVAL;
				hits_d   = '0;
				misses_d = '0;
			end
			default: begin
				status_d = ST_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			paddr_q     <= '0;
			pos_q       <= '0;
			sweep_q     <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.sweep_wr) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (ctl.fill_wr) begin
				pos_q <= pos_q + 1'b1;
				if (sts.fill_last) begin
					pending_q <= 1'b0;
				end
			end
			if (ctl.emit_load) begin
				hits_q   <= hits_d;
				misses_q <= misses_d;
				if (ctl.kind == RK_INVAL) begin
					pending_q <= 1'b0;
					pos_q     <= '0;
				end else if (ctl.kind == RK_LOOKUP && !hit) begin
					pending_q <= 1'b1;
					paddr_q   <= a_m;
					pos_q     <= '0;
				end
			end
			if (ctl.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_load) begin
			status_q <= status_d;
			rdata_q  <= rdata_d;
			base_q   <= base_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.read_data   = rdata_q;
	assign rsp.fill_base   = base_q;
	assign rsp.hits_seen   = hits_q;
	assign rsp.misses_seen = misses_q;

endmodule

// ===== rtl/direct_mapped_read_cache_top.sv =====
// Top level of the direct-mapped read cache: controller and datapath.
// An accepted request is registered and passes the issue state, then the emit state, which
// loads the result; the last fill word of a line also passes the fill-read state, which reads
// the missed word back from the data memory after the write. The next request is taken once the
// result is loaded; a waiting result delays it. After reset and each invalidate, the tag memory
// is cleared one line per cycle, taking no request; counters and fill state reset at once.
module direct_mapped_read_cache_top #(
	parameter int LINE_BYTES = 256,
	parameter int NUM_LINES  = 256,
	parameter int ADDR_BITS  = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	dmrc_req_if.sink   req,
	dmrc_rsp_if.source rsp
);
	import dmrc_pkg::*;

	ctl_cmd_t    ctl;
	ctl_status_t sts;

	dmrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	dmrc_dp #(
		.LINE_BYTES (LINE_BYTES),
		.NUM_LINES  (NUM_LINES),
		.ADDR_BITS  (ADDR_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== tb/dmrc_cache_checker.sv =====
// Checker that mirrors the cache contents and compares every response with its prediction.
module dmrc_cache_checker (
	input  logic        clk,
	input  logic        arst_n,
	dmrc_req_if         req,
	dmrc_rsp_if         rsp,
	output int unsigned failures,
	output int unsigned outstanding
);
	import dmrc_pkg::*;

	localparam int WORD_SLOTS = 16384;
	localparam int LINES      = 256;
	localparam logic [5:0] LAST_WORD = 6'd63;

	typedef struct packed {
		status_t     status;
		logic [31:0] read_data;
		logic [23:0] fill_base;
		logic [31:0] hits;
		logic [31:0] misses;
	} cache_response_t;

	bit              line_ok [LINES];
	logic [7:0]      line_tag [LINES];
	logic [31:0]     line_words [WORD_SLOTS];
	bit              fill_busy;
	logic [23:0]     fill_addr;
	logic [5:0]      fill_pos;
	logic [31:0]     hit_tally;
	logic [31:0]     miss_tally;
	cache_response_t expected_responses [$];
	int unsigned     reported;

	initial begin
		fill_busy   = 1'b0;
		fill_addr   = '0;
		fill_pos    = '0;
		hit_tally   = '0;
		miss_tally  = '0;
		failures    = 0;
		outstanding = 0;
		reported    = 0;
		foreach (line_ok[i]) line_ok[i] = 1'b0;
	end

	function automatic logic [31:0] saturating_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic cache_response_t predict_cache_response(input logic [1:0] cmd,
		input logic [23:0] addr, input logic [31:0] word_in);
		cache_response_t r;
		logic [7:0] idx;
		r        = '0;
		r.status = ST_ERROR;
		addr[1:0] = 2'b00;
		idx = addr[15:8];
		case (cmd)
			CMD_READ: begin
				if (!fill_busy) begin
					if (line_ok[idx] && line_tag[idx] == addr[23:16]) begin
						hit_tally   = saturating_inc(hit_tally);
						r.read_data = line_words[{idx, addr[7:2]}];
						r.status    = ST_HIT;
					end else begin
						miss_tally  = saturating_inc(miss_tally);
						fill_busy   = 1'b1;
						fill_addr   = addr;
						fill_pos    = '0;
						r.fill_base = {addr[23:8], 8'h00};
						r.status    = ST_MISS;
					end
				end
			end
			CMD_FILL: begin
				if (fill_busy) begin
					line_words[{fill_addr[15:8], fill_pos}] = word_in;
					if (fill_pos == LAST_WORD) begin
						line_ok[fill_addr[15:8]]  = 1'b1;
						line_tag[fill_addr[15:8]] = fill_addr[23:16];
						fill_busy   = 1'b0;
						fill_pos    = '0;
						r.read_data = line_words[{fill_addr[15:8], fill_addr[7:2]}];
						r.status    = ST_DONE;
					end else begin
						fill_pos = fill_pos + 6'd1;
						r.status = ST_TAKEN;
					end
				end
			end
			CMD_INVAL: begin
				foreach (line_ok[i]) line_ok[i] = 1'b0;
				hit_tally  = '0;
				miss_tally = '0;
				fill_busy  = 1'b0;
				fill_pos   = '0;
				r.status   = ST_INVAL;
			end
			default: ;
		endcase
		r.hits   = hit_tally;
		r.misses = miss_tally;
		return r;
	endfunction

	always @(posedge clk) begin
		cache_response_t got;
		cache_response_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = {rsp.status, rsp.read_data, rsp.fill_base, rsp.hits_seen, rsp.misses_seen};
				if (expected_responses.size() == 0) begin
					failures += 1;
					if (reported < 10) begin
						$display("unexpected response: status %0d data %h base %h hits %0d misses %0d",
							got.status, got.read_data, got.fill_base, got.hits, got.misses);
					end
					reported += 1;
				end else begin
					want = expected_responses.pop_front();
					if (got !== want) begin
						failures += 1;
						if (reported < 10) begin
							$display("response mismatch: expected status %0d data %h base %h hits %0d misses %0d",
								want.status, want.read_data, want.fill_base, want.hits, want.misses);
							$display("                   actual   status %0d data %h base %h hits %0d misses %0d",
								got.status, got.read_data, got.fill_base, got.hits, got.misses);
						end
						reported += 1;
					end
				end
			end
			if (req.valid && req.ready) begin
				expected_responses.push_back(predict_cache_response(req.cmd, req.addr, req.fill_word));
			end
			outstanding = expected_responses.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: clock, reset, request stimulus, response back-pressure and the verdict.
module tb;
	import dmrc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int WORDS_PER_LINE           = 64;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	int unsigned cycles    = 0;
	int unsigned failures;
	int unsigned outstanding;

	bit          shadow_ok [256];
	logic [7:0]  shadow_tag [256];
	bit          shadow_filling = 1'b0;
	logic [23:0] shadow_fill_addr = '0;
	int          shadow_beats = 0;

	dmrc_req_if req_ch ();
	dmrc_rsp_if rsp_ch ();

	direct_mapped_read_cache_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	dmrc_cache_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles += 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input logic [1:0] cmd, input logic [23:0] addr,
		input logic [31:0] word_in);
		logic [7:0] idx;
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid     = 1'b1;
		req_ch.cmd       = cmd;
		req_ch.addr      = addr;
		req_ch.fill_word = word_in;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
		idx = addr[15:8];
		case (cmd)
			CMD_READ: begin
				if (!shadow_filling && !(shadow_ok[idx] && shadow_tag[idx] == addr[23:16])) begin
					shadow_filling   = 1'b1;
					shadow_fill_addr = addr;
					shadow_beats     = 0;
				end
			end
			CMD_FILL: begin
				if (shadow_filling) begin
					shadow_beats += 1;
					if (shadow_beats == WORDS_PER_LINE) begin
						shadow_ok[shadow_fill_addr[15:8]]  = 1'b1;
						shadow_tag[shadow_fill_addr[15:8]] = shadow_fill_addr[23:16];
						shadow_filling = 1'b0;
					end
				end
			end
			CMD_INVAL: begin
				foreach (shadow_ok[i]) shadow_ok[i] = 1'b0;
				shadow_filling = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic drain();
		req_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic random_request();
		int unsigned r;
		logic [23:0] a;
		logic [31:0] w;
		logic [7:0]  pick_tag;
		logic [7:0]  pick_idx;
		r = $urandom_range(99);
		a = 24'($urandom_range(24'hFFFFFF));
		case ($urandom_range(15))
			0:       w = '0;
			1:       w = '1;
			default: w = $urandom();
		endcase
		if (shadow_filling) begin
			if (r < 94) send_request(CMD_FILL, a, w);
			else if (r < 97) send_request(CMD_READ, a, w);
			else if (r < 99) send_request(CMD_UNUSED, a, w);
			else send_request(CMD_INVAL, a, w);
		end else if (r < 2) begin
			send_request(CMD_INVAL, a, w);
		end else if (r < 5) begin
			send_request(CMD_FILL, a, w);
		end else if (r < 7) begin
			send_request(CMD_UNUSED, a, w);
		end else begin
			pick_tag = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
			case ($urandom_range(2))
				0:       pick_idx = 8'h00;
				1:       pick_idx = 8'h5A;
				default: pick_idx = 8'hFF;
			endcase
			if (r < 55) a = {shadow_fill_addr[23:8], a[7:0]};
			else if (r < 88) a = {pick_tag, pick_idx, a[7:0]};
			send_request(CMD_READ, a, w);
		end
	endtask

	task automatic run_phase(input int items, input int unsigned idle, input int unsigned stall);
		idle_pct  = idle;
		stall_pct = stall;
		repeat (items) random_request();
		drain();
	endtask

	initial begin
		int i;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = CMD_READ;
		req_ch.addr      = '0;
		req_ch.fill_word = '0;
		rsp_ch.ready     = 1'b0;
		foreach (shadow_ok[k]) shadow_ok[k] = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		send_request(CMD_FILL, 24'h000000, 32'hFFFFFFFF);
		send_request(CMD_UNUSED, 24'hFFFFFF, 32'h00000000);
		send_request(CMD_READ, 24'hFFFFFF, 32'h00000000);
		send_request(CMD_READ, 24'h000000, 32'hFFFFFFFF);
		for (i = 0; i < WORDS_PER_LINE; i++) begin
			send_request(CMD_FILL, 24'($urandom_range(24'hFFFFFF)),
				(i == 0) ? 32'h00000000 : (i == WORDS_PER_LINE - 1) ? 32'hFFFFFFFF : $urandom());
		end
		send_request(CMD_READ, 24'hFFFFFC, 32'h00000000);
		send_request(CMD_READ, 24'hFFFF03, 32'h00000000);
		send_request(CMD_READ, 24'hFFFF80, 32'h00000000);
		// Hold the requests back until every response is in.
		drain();
		send_request(CMD_READ, 24'h00FF00, 32'h00000000);
		send_request(CMD_FILL, 24'h000000, 32'hA5A5A5A5);
		send_request(CMD_FILL, 24'h000000, 32'h5A5A5A5A);
		send_request(CMD_INVAL, 24'h000000, 32'h00000000);
		send_request(CMD_FILL, 24'hFFFFFF, 32'h12345678);
		send_request(CMD_READ, 24'hFFFFFC, 32'h00000000);
		send_request(CMD_INVAL, 24'hFFFFFF, 32'hFFFFFFFF);
		drain();

		run_phase(230, 0, 0);
		run_phase(220, 81, 0);
		run_phase(220, 0, 81);
		run_phase(220, 25, 25);

		drain();
		repeat (20) @(negedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
